// ===== rtl/bf3_pkg.sv =====
// Shared types and constants for the 3x3 box filter.
package bf3_pkg;

	// Field widths of the payload and configuration registers
	localparam int SAMPLE_W      = 16;
	localparam int COL_W         = 8;
	localparam int ROW_W         = 10;
	localparam int GRID_WIDTH_W  = 9;
	localparam int GRID_HEIGHT_W = 11;
	localparam int CFG_W         = 11;
	localparam int CFG_IDX_W     = 2;

	// Parameter defaults
	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int RESET_DIM    = 256;

	// Window arithmetic: divide by 9 as multiply by ceil(2^23/9), shift by 23.
	// Exact for sums below 2^21; a 3x3 sum of 16-bit samples fits in 20 bits.
	localparam int COLSUM_W  = SAMPLE_W + 2;
	localparam int SUM_W     = SAMPLE_W + 4;
	localparam int RECIP_W   = 20;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int DIV_SHIFT = 23;
	localparam logic [RECIP_W-1:0] RECIP_9 = 20'd932068;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// One window column: two rows above and the current row
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} column_t;

	// One line buffer entry: both rows above at one column
	typedef struct packed {
		sample_t two_above;
		sample_t above;
	} lines_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] height_in;
		logic                frame_start;
	} in_beat_t;

	typedef struct packed {
		logic [COL_W-1:0]    out_col;
		logic [ROW_W-1:0]    out_row;
		logic [SAMPLE_W-1:0] smoothed;
		logic                run_last;
	} out_beat_t;

endpackage

// ===== rtl/box_filter_3x3_grid_core.sv =====
// Top level of the 3x3 box filter over a raster-order height grid.
//
// Input channel in_valid/in_ready/in_data takes one sample per beat, row by row,
// left to right; frame_start on a beat restarts the position at cell (0,0).
// Output channel out_valid/out_ready/out_data gives results with their cell
// coordinates: a border cell reports zero when it arrives, an interior cell
// reports its truncated 3x3 mean when its lower-right neighbor arrives.
// cfg_we/cfg_index/cfg_data write grid_width (0) or grid_height (1); a write
// also returns the position to (0,0). Write only while idle.
// Throughput: one sample per cycle while out_ready is high, set by the single
// line buffer port pair and the one-result-per-beat output; samples that make
// two results (interior neighbor on the last row or column) drain at one
// result per cycle through an 8-entry result queue.
// A result passes stages 1, 2 and 3 and then the result queue before it is visible.
// When the receiver stalls, results collect in the queue and in_ready drops
// once the queue plus in-flight results could no longer take two more.
// Reset clears the position, the dimensions (both 256, capped by MAX_COLS and
// MAX_ROWS) and the pipeline; line buffer contents are undefined until written.
module box_filter_3x3_grid_core #(
	parameter int MAX_COLS = bf3_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = bf3_pkg::DEF_MAX_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bf3_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bf3_pkg::out_beat_t              out_data,
	input  logic                            cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]       cfg_data
);
	import bf3_pkg::*;

	localparam int CW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int WCMP   = (CW + 1 > GRID_WIDTH_W) ? CW + 1 : GRID_WIDTH_W;
	localparam int HCMP   = (RW + 1 > GRID_HEIGHT_W) ? RW + 1 : GRID_HEIGHT_W;
	localparam int WL_RST = ((RESET_DIM < MAX_COLS) ? RESET_DIM : MAX_COLS) - 1;
	localparam int HL_RST = ((RESET_DIM < MAX_ROWS) ? RESET_DIM : MAX_ROWS) - 1;

	// last column / last row index, already clamped
	logic [CW-1:0] wl_q;
	logic [RW-1:0] hl_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [WCMP-1:0] gw_x;
	logic [HCMP-1:0] gh_x;
	logic [CW-1:0]   wl_new;
	logic [RW-1:0]   hl_new;
	logic            cfg_hit;

	// clamp a written dimension to 1..MAX and keep it as a last index
	assign gw_x = WCMP'(cfg_data[GRID_WIDTH_W-1:0]);
	assign gh_x = HCMP'(cfg_data[GRID_HEIGHT_W-1:0]);

	always_comb begin
		priority if (gw_x == '0) begin
			wl_new = '0;
		end else if (gw_x > WCMP'(MAX_COLS)) begin
			wl_new = CW'(MAX_COLS - 1);
		end else begin
			wl_new = CW'(gw_x - 1'b1);
		end
		priority if (gh_x == '0) begin
			hl_new = '0;
		end else if (gh_x > HCMP'(MAX_ROWS)) begin
			hl_new = RW'(MAX_ROWS - 1);
		end else begin
			hl_new = RW'(gh_x - 1'b1);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	// input stage: position of the arriving cell and its result count
	logic          in_fire;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic          inner0;
	logic          border0;
	logic [1:0]    n0;
	logic          pop;
	logic [FIFO_CW-1:0] used_q;

	assign in_fire = in_valid && in_ready;
	assign pop     = out_valid && out_ready;
	assign c0      = in_data.frame_start ? '0 : col_q;
	assign r0      = in_data.frame_start ? '0 : row_q;
	assign inner0  = (r0 >= RW'(2)) && (c0 >= CW'(2));
	assign border0 = (r0 == '0) || (r0 == hl_q) || (c0 == '0) || (c0 == wl_q);
	assign n0      = 2'(inner0) + 2'(border0);
	assign in_ready = (used_q <= FIFO_CW'(FIFO_DEPTH - 2));

	// dimensions and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= CW'(WL_RST);
			hl_q  <= RW'(HL_RST);
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (in_fire) begin
				if (c0 == wl_q) begin
					col_q <= '0;
					row_q <= (r0 == hl_q) ? '0 : RW'(r0 + 1'b1);
				end else begin
					col_q <= CW'(c0 + 1'b1);
					row_q <= r0;
				end
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
				if (cfg_index == REG_GRID_WIDTH) begin
					wl_q <= wl_new;
				end else begin
					hl_q <= hl_new;
				end
			end
		end
	end

	// results queued or still in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= FIFO_CW'(used_q + (in_fire ? FIFO_CW'(n0) : FIFO_CW'(0))
				- FIFO_CW'(pop));
		end
	end

	// stage 1: line buffer read returns, window column forms
	logic          v_s1;
	sample_t       sample_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;
	logic          inner_s1;
	logic          border_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_data.height_in;
			c_s1      <= c0;
			r_s1      <= r0;
			inner_s1  <= inner0;
			border_s1 <= border0;
		end
	end

	lines_t  lb_rd;
	lines_t  lb_wd;
	column_t cur_col;
	column_t cell0_col;
	logic [COLSUM_W-1:0] cs0;
	logic [COLSUM_W-1:0] cs1;
	logic [SUM_W-1:0]    win_sum;

	assign lb_wd   = '{two_above: lb_rd.above, above: sample_s1};
	assign cur_col = '{top: lb_rd.two_above, mid: lb_rd.above, bot: sample_s1};

	bf3_linebuf #(
		.MAX_COLS (MAX_COLS)
	) u_linebuf (
		.clk   (clk),
		.we    (v_s1),
		.waddr (c_s1),
		.wdata (lb_wd),
		.raddr (c0),
		.rdata (lb_rd)
	);

	// two window cells: previous column, then the one before it
	bf3_cell u_cell0 (
		.clk        (clk),
		.en         (v_s1),
		.col_in     (cur_col),
		.col_out    (cell0_col),
		.colsum_out (cs0)
	);

	bf3_cell u_cell1 (
		.clk        (clk),
		.en         (v_s1),
		.col_in     (cell0_col),
		.col_out    (),
		.colsum_out (cs1)
	);

	assign win_sum = SUM_W'(cur_col.top) + SUM_W'(cur_col.mid) + SUM_W'(cur_col.bot)
		+ SUM_W'(cs0) + SUM_W'(cs1);

	// stage 2: 3x3 sum registered
	logic             v_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [CW-1:0]    c_s2;
	logic [RW-1:0]    r_s2;
	logic             inner_s2;
	logic             border_s2;

	// stage 3: reciprocal product registered
	logic              v_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [CW-1:0]     c_s3;
	logic [RW-1:0]     r_s3;
	logic              inner_s3;
	logic              border_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2    <= win_sum;
		c_s2      <= c_s1;
		r_s2      <= r_s1;
		inner_s2  <= inner_s1;
		border_s2 <= border_s1;
		prod_s3   <= PROD_W'(sum_s2) * PROD_W'(RECIP_9);
		c_s3      <= c_s2;
		r_s3      <= r_s2;
		inner_s3  <= inner_s2;
		border_s3 <= border_s2;
	end

	// result beats: interior mean first, then the border zero
	out_beat_t res_int;
	out_beat_t res_bdr;
	out_beat_t push_d0;
	logic [1:0] push_n;

	assign res_int = '{
		out_col:  COL_W'(CW'(c_s3 - 1'b1)),
		out_row:  ROW_W'(RW'(r_s3 - 1'b1)),
		smoothed: prod_s3[DIV_SHIFT +: SAMPLE_W],
		run_last: !border_s3
	};
	assign res_bdr = '{
		out_col:  COL_W'(c_s3),
		out_row:  ROW_W'(r_s3),
		smoothed: '0,
		run_last: 1'b1
	};

	always_comb begin
		push_n  = v_s3 ? (2'(inner_s3) + 2'(border_s3)) : 2'd0;
		push_d0 = inner_s3 ? res_int : res_bdr;
	end

	bf3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_d0   (push_d0),
		.push_d1   (res_bdr),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/bf3_cell.sv =====
// Window cell: holds one column of the 3x3 window and its sum, shifts to its neighbor.
module bf3_cell (
	input  logic                          clk,
	input  logic                          en,
	input  bf3_pkg::column_t              col_in,
	output bf3_pkg::column_t              col_out,
	output logic [bf3_pkg::COLSUM_W-1:0]  colsum_out
);
	import bf3_pkg::*;

	column_t             col_q;
	logic [COLSUM_W-1:0] colsum_q;

	// load the next column and its sum on each beat
	always_ff @(posedge clk) begin
		if (en) begin
			col_q    <= col_in;
			colsum_q <= COLSUM_W'(col_in.top) + COLSUM_W'(col_in.mid)
				+ COLSUM_W'(col_in.bot);
		end
	end

	assign col_out    = col_q;
	assign colsum_out = colsum_q;

endmodule

// ===== rtl/bf3_linebuf.sv =====
// Line buffer memory: both previous rows, one entry per column, registered read.
module bf3_linebuf #(
	parameter int MAX_COLS = bf3_pkg::DEF_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_COLS)-1:0]   waddr,
	input  bf3_pkg::lines_t               wdata,
	input  logic [$clog2(MAX_COLS)-1:0]   raddr,
	output bf3_pkg::lines_t               rdata
);
	import bf3_pkg::*;

	lines_t mem [MAX_COLS];
	lines_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bf3_outq.sv =====
// Result queue: takes zero, one or two results per cycle, hands out one per beat.
module bf3_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  bf3_pkg::out_beat_t  push_d0,
	input  bf3_pkg::out_beat_t  push_d1,
	input  logic                pop,
	output logic                out_valid,
	output bf3_pkg::out_beat_t  out_data
);
	import bf3_pkg::*;

	out_beat_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   head_q;
	logic [FIFO_AW-1:0]   tail_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic [FIFO_AW-1:0]   tail_p1;

	assign tail_p1 = FIFO_AW'(tail_q + 1'b1);

	// entry writes
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[tail_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			fifo_q[tail_p1] <= push_d1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= FIFO_AW'(tail_q + FIFO_AW'(push_n));
			if (pop) begin
				head_q <= FIFO_AW'(head_q + 1'b1);
			end
			cnt_q <= FIFO_CW'(cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop));
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[head_q];

endmodule

// ===== test/box_filter_3x3_grid_core_tb.sv =====
// Self-checking testbench for the 3x3 box filter core: random grids, stalls and checks.
module box_filter_3x3_grid_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bf3_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int TARGET_ITEMS   = 850;
	localparam int MAX_REPORTS    = 10;

	// Indexes past the two real registers; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_beat_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	box_filter_3x3_grid_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus and expectation stores
	in_beat_t  pending_beats[$];
	out_beat_t expected_cells[$];
	int        items_sent = 0;
	int        fail_count = 0;
	int        idle_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      hold_start = 1'b0;
	int        hold_left;

	// Filter shadow state: dimensions, position, line buffers, window
	logic [GRID_WIDTH_W-1:0]  shadow_width = GRID_WIDTH_W'(RESET_DIM);
	logic [GRID_HEIGHT_W-1:0] shadow_height = GRID_HEIGHT_W'(RESET_DIM);
	int unsigned              col_pos = 0;
	int unsigned              row_pos = 0;
	logic [SAMPLE_W-1:0]      above_line [DEF_MAX_COLS];
	logic [SAMPLE_W-1:0]      two_above_line [DEF_MAX_COLS];
	logic [SAMPLE_W-1:0]      win [6];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected results for one accepted sample
	task automatic predict_cells(input in_beat_t beat);
		int unsigned         w, h, c, r, total;
		logic [SAMPLE_W-1:0] s, top, mid;
		bit                  inner, border;
		out_beat_t           res;
		w = (shadow_width == 0) ? 1 :
			(shadow_width > DEF_MAX_COLS) ? DEF_MAX_COLS : shadow_width;
		h = (shadow_height == 0) ? 1 :
			(shadow_height > DEF_MAX_ROWS) ? DEF_MAX_ROWS : shadow_height;
		s = beat.height_in;
		if (beat.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		top = two_above_line[c];
		mid = above_line[c];
		inner = (r >= 2) && (c >= 2);
		border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		// interior cell up-left of the arriving sample comes first
		if (inner) begin
			total = top + mid + s;
			for (int i = 0; i < 6; i++) total += win[i];
			res.out_col  = COL_W'(c - 1);
			res.out_row  = ROW_W'(r - 1);
			res.smoothed = SAMPLE_W'(total / 9);
			res.run_last = !border;
			expected_cells.push_back(res);
		end
		if (border) begin
			res.out_col  = COL_W'(c);
			res.out_row  = ROW_W'(r);
			res.smoothed = '0;
			res.run_last = 1'b1;
			expected_cells.push_back(res);
		end
		// slide the window one column and update both line buffers
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top;
		win[4] = mid;
		win[5] = s;
		two_above_line[c] = mid;
		above_line[c] = s;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
	endtask

	// Input driver: offers the next pending beat, holds it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_beats.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_start) begin
			hold_start = 1'b0;
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		out_beat_t exp_cell;
		if (arst_n) begin
			if (in_valid && in_ready) predict_cells(in_data);
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					note_failure($sformatf("unexpected result col=%0d row=%0d val=%0d last=%0b",
						out_data.out_col, out_data.out_row, out_data.smoothed,
						out_data.run_last));
				end else begin
					exp_cell = expected_cells.pop_front();
					if (out_data.out_col !== exp_cell.out_col ||
						out_data.out_row !== exp_cell.out_row ||
						out_data.smoothed !== exp_cell.smoothed ||
						out_data.run_last !== exp_cell.run_last) begin
						note_failure($sformatf(
							"mismatch exp col=%0d row=%0d val=%0d last=%0b, got col=%0d row=%0d val=%0d last=%0b",
							exp_cell.out_col, exp_cell.out_row, exp_cell.smoothed,
							exp_cell.run_last, out_data.out_col, out_data.out_row,
							out_data.smoothed, out_data.run_last));
					end
				end
			end
		end
	end

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Register write; only called while the filter is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRID_WIDTH) begin
			shadow_width = val[GRID_WIDTH_W-1:0];
			col_pos = 0;
			row_pos = 0;
		end else if (idx == REG_GRID_HEIGHT) begin
			shadow_height = val[GRID_HEIGHT_W-1:0];
			col_pos = 0;
			row_pos = 0;
		end
	endtask

	// Wait for all beats out and all results back, then let the pipe empty
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_cells.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
			default: begin send_idle_pct = 14; recv_stall_pct = 14; end
		endcase
	endtask

	task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
		in_beat_t beat;
		beat.height_in = s;
		beat.frame_start = fs;
		pending_beats.push_back(beat);
		items_sent++;
	endtask

	// Heights skewed toward the extremes
	function automatic logic [SAMPLE_W-1:0] rand_height();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Grid dimension, mostly in the range that reaches interior cells
	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0: return $urandom_range(1, 2);
			1: return $urandom_range(9, 16);
			default: return $urandom_range(3, 8);
		endcase
	endfunction

	// One grid in raster order; may be cut short or broken by a stray restart
	task automatic send_grid(input int w, input int h, input bit restart, output bit cut);
		int n;
		bit fs;
		n = w * h;
		cut = ($urandom_range(0, 7) == 0);
		if (cut) n = $urandom_range(1, n);
		for (int i = 0; i < n; i++) begin
			if (i == 0) fs = restart ? 1'b1 : 1'($urandom_range(0, 1));
			else fs = ($urandom_range(0, 39) == 0);
			queue_sample(rand_height(), fs);
		end
	endtask

	initial begin
		int  w, h, grids;
		bit  cut, restart;
		int  phase;
		logic [CFG_W-1:0] val;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: 3x3 grids, all-max, partial grid with restart, checkerboard
		write_reg(REG_GRID_WIDTH, CFG_W'(3));
		write_reg(REG_GRID_HEIGHT, CFG_W'(3));
		@(negedge clk);
		for (int i = 0; i < 9; i++) queue_sample('1, i == 0);
		queue_sample(16'hAAAA, 1'b0);
		queue_sample(16'h5555, 1'b0);
		queue_sample(16'hAAAA, 1'b0);
		queue_sample(16'h5555, 1'b0);
		for (int i = 0; i < 9; i++) queue_sample(i[0] ? 16'hFFFF : 16'h0000, i == 0);
		wait_drained();

		// Zero in both registers acts as a 1x1 grid: every sample is a border cell
		write_reg(REG_GRID_WIDTH, '0);
		write_reg(REG_GRID_HEIGHT, '0);
		@(negedge clk);
		queue_sample('1, 1'b0);
		queue_sample('0, 1'b1);
		queue_sample(16'h8001, 1'b0);
		wait_drained();

		// All-ones writes clamp to the largest grid; long receiver hold-off
		write_reg(REG_GRID_WIDTH, '1);
		write_reg(REG_GRID_HEIGHT, '1);
		set_idling(1);
		@(negedge clk);
		for (int i = 0; i < 260; i++) queue_sample(rand_height(), i == 0);
		hold_start = 1'b1;
		wait_drained();

		// Random grids, rotating through the idling phases
		phase = 0;
		restart = 1'b0;
		while (items_sent < TARGET_ITEMS) begin
			set_idling(phase % 4);
			w = pick_dim();
			h = pick_dim();
			wait_drained();
			// upper data bits are ignored by the width register
			val = CFG_W'(w);
			if (w == 1 && $urandom_range(0, 1)) val = '0;
			val[GRID_HEIGHT_W-1:GRID_WIDTH_W] = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 1)) begin
				write_reg(REG_GRID_WIDTH, val);
				write_reg(REG_GRID_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(h));
			end else begin
				write_reg(REG_GRID_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(h));
				write_reg(REG_GRID_WIDTH, val);
			end
			@(negedge clk);
			grids = (w * h > 64) ? 1 : $urandom_range(1, 3);
			for (int g = 0; g < grids; g++) begin
				send_grid(w, h, restart, cut);
				restart = cut;
				// spare-index write mid-stream must leave the position alone
				if ($urandom_range(0, 5) == 0) begin
					wait_drained();
					write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
					@(negedge clk);
				end
			end
			phase++;
		end

		wait_drained();
		repeat (12) @(negedge clk);
		fail_count += expected_cells.size();
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
